### sv/pis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types and constants of the interval-censored Peto score block.
// ----------------------------------------------------------------------------
package pis_pkg;

    localparam int TIME_W  = 32;
    localparam int SURV_W  = 17;
    localparam int SCORE_W = 22;

    localparam logic [SURV_W-1:0]  SURV_ONE  = 17'h10000;
    localparam logic [SCORE_W-1:0] SCORE_MIN = 22'h200000;
    // 32.0 in Q16, reduced to the score width.
    localparam logic [SCORE_W-1:0] Q16_BIAS  = 22'h200000;

    localparam logic [63:0] BIAS_Q44   = 64'h0002_0000_0000_0000;
    localparam logic [63:0] ONE_Q44    = 64'h0000_1000_0000_0000;
    localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0800_0000;

    localparam logic [7:0] K_FIRST = 8'd3;
    localparam logic [7:0] K_STEP  = 8'd2;
    localparam logic [7:0] K_LIMIT = 8'd200;

    localparam logic [6:0] Z_STEPS    = 7'd60;
    localparam logic [6:0] FULL_STEPS = 7'd64;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [SURV_W-1:0] sl;
        logic [SURV_W-1:0] sr;
    } t_pair;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [63:0] a;
        logic [63:0] b;
        logic [19:0] rem0;
        logic [19:0] dvs;
        logic [6:0]  steps;
    } t_mdu_req;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
        logic [63:0]  quot;
    } t_mdu_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AT_START,
        ST_AT_DIV,
        ST_AT_SQ,
        ST_AT_CHK,
        ST_AT_TMUL,
        ST_AT_TDIV,
        ST_LN_START,
        ST_LN_MUL,
        ST_LN_DONE,
        ST_NA,
        ST_NB,
        ST_QDIV,
        ST_ROUND,
        ST_OUT
    } t_back_state;

    typedef enum logic {RET_LN2, RET_LN} t_ret;
    typedef enum logic {STEP_A, STEP_B} t_step;

endpackage
`default_nettype wire

### sv/peto_interval_score.sv
`default_nettype none
// ----------------------------------------------------------------------------
// peto_interval_score
// Interval-censored Peto score: log-rank or Wilcoxon score per sample.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------
//  in      | i_in_valid / o_in_ready    | left, right, grid time, surv, last
//  out     | o_out_valid / i_out_ready  | o_score
//  cfg     | i_cfg_wr_en                | i_cfg_wr_data (score mode)
//
// The front end takes one grid point per cycle while the pair queue has room.
// The back end forms a log-rank score on the bit-serial multiply/divide
// unit running the atanh series and a Wilcoxon score directly from the
// pair. Reset is synchronous; it clears the sequencer and queue state and
// the front end's held survival values. A stalled output holds the back
// end, which then stops the front once the queue of two pairs is full.
module peto_interval_score
    import pis_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic                 i_cfg_wr_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [TIME_W-1:0]    i_left_time,
    input  wire logic [TIME_W-1:0]    i_right_time,
    input  wire logic [TIME_W-1:0]    i_grid_time,
    input  wire logic [SURV_W-1:0]    i_surv_value,
    input  wire logic                 i_last_point,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [SCORE_W-1:0] o_score
);

    logic  q_ready, q_valid, push, pop;
    t_pair push_pair, q_data;

    pis_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_left_time  (i_left_time),
        .i_right_time (i_right_time),
        .i_grid_time  (i_grid_time),
        .i_surv_value (i_surv_value),
        .i_last_point (i_last_point),
        .i_q_ready    (q_ready),
        .o_push       (push),
        .o_pair       (push_pair)
    );

    pis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_pair),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rdata (q_data)
    );

    pis_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_data      (q_data),
        .o_q_pop       (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_score       (o_score)
    );

`ifndef SYNTH
    // A finished sample is waiting in the queue right after its last word.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_point) |=> q_valid)
        else $error("sample pair lost after last word");

    // No Peto score rises above one.
    a_score_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_score <= $signed(22'sd65536)))
        else $error("score above one");
`endif

endmodule
`default_nettype wire

### sv/pis_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pis_front
// Takes grid points one per cycle when the queue has room; picks the left and
// right survival values of each sample and pushes the pair on the last point.
// ----------------------------------------------------------------------------
module pis_front
    import pis_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [TIME_W-1:0] i_left_time,
    input  wire logic [TIME_W-1:0] i_right_time,
    input  wire logic [TIME_W-1:0] i_grid_time,
    input  wire logic [SURV_W-1:0] i_surv_value,
    input  wire logic              i_last_point,
    input  wire logic              i_q_ready,
    output logic                   o_push,
    output t_pair                  o_pair
);

    logic              r_left_found, r_ra_found, r_ry_found;
    logic [SURV_W-1:0] r_held_left, r_held_right, r_ra_surv, r_ry_surv;

    logic              accept, right_hit, lf_hit, lf_new, ra_hit, ry_hit;
    logic              ra_found_new, ry_found_new;
    logic [SURV_W-1:0] s, hl_new, ra_surv_new, ry_surv_new, sr_sel;

    always_comb begin
        s            = (i_surv_value > SURV_ONE) ? SURV_ONE : i_surv_value;
        right_hit    = (i_right_time <= i_grid_time);
        lf_hit       = !r_left_found && (i_left_time <= i_grid_time);
        lf_new       = r_left_found | lf_hit;
        hl_new       = lf_hit ? s : r_held_left;
        ra_hit       = lf_new && !r_ra_found && right_hit;
        ra_found_new = r_ra_found | ra_hit;
        ra_surv_new  = ra_hit ? s : r_ra_surv;
        ry_hit       = !r_ry_found && right_hit;
        ry_found_new = r_ry_found | ry_hit;
        ry_surv_new  = ry_hit ? s : r_ry_surv;
        if (lf_new) begin
            sr_sel = ra_found_new ? ra_surv_new : r_held_right;
        end else begin
            sr_sel = ry_found_new ? ry_surv_new : r_held_right;
        end
    end

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid & i_q_ready;
    assign o_push     = accept & i_last_point;
    assign o_pair     = '{sl: hl_new, sr: sr_sel};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_found <= 1'b0;
            r_ra_found   <= 1'b0;
            r_ry_found   <= 1'b0;
            r_held_left  <= '0;
            r_held_right <= '0;
            r_ra_surv    <= '0;
            r_ry_surv    <= '0;
        end else if (accept) begin
            r_held_left <= hl_new;
            r_ra_surv   <= ra_surv_new;
            r_ry_surv   <= ry_surv_new;
            if (i_last_point) begin
                r_left_found <= 1'b0;
                r_ra_found   <= 1'b0;
                r_ry_found   <= 1'b0;
                r_held_right <= sr_sel;
            end else begin
                r_left_found <= lf_new;
                r_ra_found   <= ra_found_new;
                r_ry_found   <= ry_found_new;
            end
        end
    end

endmodule
`default_nettype wire

### sv/pis_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pis_queue
// Short queue of survival pairs between the front and the back end.
// ----------------------------------------------------------------------------
module pis_queue
    import pis_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_pair      i_wdata,
    output logic       o_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_pair      o_rdata
);

    t_pair              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

### sv/pis_mdu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pis_mdu
// Bit-serial multiply and restoring divide unit, one bit per cycle.
// ----------------------------------------------------------------------------
module pis_mdu
    import pis_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_mdu_req  i_req,
    output t_mdu_rsp  o_rsp
);

    logic         r_busy, r_done, r_is_div;
    logic [6:0]   r_cnt, r_steps;
    logic [63:0]  r_a, r_b, r_dvd, r_quot;
    logic [127:0] r_prod;
    logic [19:0]  r_rem, r_dvs;

    logic [19:0]  trial, n_rem;
    logic         ge;
    logic [64:0]  msum;

    always_comb begin
        trial = {r_rem[18:0], r_dvd[63]};
        ge    = (trial >= r_dvs);
        n_rem = ge ? (trial - r_dvs) : trial;
        msum  = {1'b0, r_prod[127:64]} + (r_b[0] ? {1'b0, r_a} : 65'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == r_steps - 1'b1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_is_div <= i_req.is_div;
            r_steps  <= i_req.steps;
            r_a      <= i_req.a;
            r_b      <= i_req.b;
            r_prod   <= '0;
            r_dvd    <= i_req.a;
            r_rem    <= i_req.rem0;
            r_dvs    <= i_req.dvs;
            r_quot   <= '0;
        end else if (r_busy) begin
            if (r_is_div) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[62:0], ge};
                r_dvd  <= {r_dvd[62:0], 1'b0};
            end else begin
                r_prod <= {msum, r_prod[63:1]};
                r_b    <= {1'b0, r_b[63:1]};
            end
        end
    end

    assign o_rsp = '{done: r_done, prod: r_prod, quot: r_quot};

endmodule
`default_nettype wire

### sv/pis_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pis_back
// Sequencer that turns a survival pair into a Peto score (log-rank: atanh
// series logarithms and the difference quotient, on the shared serial unit).
// ----------------------------------------------------------------------------
module pis_back
    import pis_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic               i_q_valid,
    input  t_pair                   i_q_data,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [SCORE_W-1:0] o_score
);

    t_back_state r_state, n_state;
    t_ret        r_ret, n_ret;
    t_step       r_step, n_step;

    logic               r_score_mode;
    logic [SURV_W-1:0]  r_sl, n_sl, r_sr, n_sr, r_x, n_x;
    logic [4:0]         r_e, n_e;
    logic [17:0]        r_atn, n_atn, r_atd, n_atd;
    logic [63:0]        r_term, n_term, r_zz, n_zz, r_sum, n_sum;
    logic [63:0]        r_l2, n_l2, r_at, n_at, r_ln, n_ln, r_na, n_na;
    logic [63:0]        r_acc, n_acc, rnd;
    logic [7:0]         r_k, n_k;
    logic [SCORE_W-1:0] r_score, n_score;

    logic [4:0]         e_x;
    logic [17:0]        p_x;

    t_mdu_req req;
    t_mdu_rsp rsp;

    pis_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // floor(log2 x) for x up to 2^16
    always_comb begin
        e_x = '0;
        for (int i = 0; i < SURV_W; i++) begin
            if (r_x[i]) begin
                e_x = 5'(i);
            end
        end
        p_x = 18'(1) << e_x;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_step  = r_step;
        n_sl    = r_sl;
        n_sr    = r_sr;
        n_x     = r_x;
        n_e     = r_e;
        n_atn   = r_atn;
        n_atd   = r_atd;
        n_term  = r_term;
        n_zz    = r_zz;
        n_sum   = r_sum;
        n_l2    = r_l2;
        n_at    = r_at;
        n_ln    = r_ln;
        n_na    = r_na;
        n_acc   = r_acc;
        n_k     = r_k;
        n_score = r_score;
        req     = '0;
        o_q_pop = 1'b0;
        rnd     = r_acc + ROUND_HALF;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_sl    = i_q_data.sl;
                    n_sr    = i_q_data.sr;
                    if (!r_score_mode) begin
                        n_score = SCORE_W'(i_q_data.sl) + SCORE_W'(i_q_data.sr)
                                  - SCORE_W'(SURV_ONE);
                        n_state = ST_OUT;
                    end else if (i_q_data.sl <= i_q_data.sr && i_q_data.sl == '0) begin
                        n_score = SCORE_MIN;
                        n_state = ST_OUT;
                    end else begin
                        n_atn   = 18'd1;
                        n_atd   = 18'd3;
                        n_ret   = RET_LN2;
                        n_state = ST_AT_START;
                    end
                end
            end
            ST_AT_START: begin
                req.start  = 1'b1;
                req.is_div = 1'b1;
                req.rem0   = 20'(r_atn);
                req.dvs    = 20'(r_atd);
                req.steps  = Z_STEPS;
                n_state    = ST_AT_DIV;
            end
            ST_AT_DIV: begin
                if (rsp.done) begin
                    n_term    = rsp.quot;
                    req.start = 1'b1;
                    req.a     = rsp.quot;
                    req.b     = rsp.quot;
                    req.steps = FULL_STEPS;
                    n_state   = ST_AT_SQ;
                end
            end
            ST_AT_SQ: begin
                if (rsp.done) begin
                    n_zz    = rsp.prod[123:60];
                    n_sum   = r_term;
                    n_k     = K_FIRST;
                    n_state = ST_AT_CHK;
                end
            end
            ST_AT_CHK: begin
                if (r_term != '0 && r_k < K_LIMIT) begin
                    req.start = 1'b1;
                    req.a     = r_term;
                    req.b     = r_zz;
                    req.steps = FULL_STEPS;
                    n_state   = ST_AT_TMUL;
                end else if (r_ret == RET_LN2) begin
                    n_l2    = {15'd0, r_sum[63:15]};
                    n_x     = r_sl;
                    n_step  = STEP_A;
                    n_state = ST_LN_START;
                end else begin
                    n_at      = {15'd0, r_sum[63:15]};
                    req.start = 1'b1;
                    req.a     = r_l2;
                    req.b     = 64'(r_e);
                    req.steps = FULL_STEPS;
                    n_state   = ST_LN_MUL;
                end
            end
            ST_AT_TMUL: begin
                if (rsp.done) begin
                    n_term     = rsp.prod[123:60];
                    req.start  = 1'b1;
                    req.is_div = 1'b1;
                    req.a      = rsp.prod[123:60];
                    req.dvs    = 20'(r_k);
                    req.steps  = FULL_STEPS;
                    n_state    = ST_AT_TDIV;
                end
            end
            ST_AT_TDIV: begin
                if (rsp.done) begin
                    n_sum   = r_sum + rsp.quot;
                    n_k     = r_k + K_STEP;
                    n_state = ST_AT_CHK;
                end
            end
            ST_LN_START: begin
                n_e     = e_x;
                n_atn   = 18'(r_x) - p_x;
                n_atd   = 18'(r_x) + p_x;
                n_ret   = RET_LN;
                n_state = ST_AT_START;
            end
            ST_LN_MUL: begin
                if (rsp.done) begin
                    n_ln    = rsp.prod[63:0] + r_at;
                    n_state = ST_LN_DONE;
                end
            end
            ST_LN_DONE: begin
                if (r_step == STEP_A) begin
                    if (r_sl <= r_sr) begin
                        n_acc   = BIAS_Q44 + ONE_Q44 + r_ln - {r_l2[59:0], 4'd0};
                        n_state = ST_ROUND;
                    end else begin
                        req.start = 1'b1;
                        req.a     = r_ln;
                        req.b     = 64'(r_sl);
                        req.steps = FULL_STEPS;
                        n_state   = ST_NA;
                    end
                end else begin
                    req.start = 1'b1;
                    req.a     = r_ln;
                    req.b     = 64'(r_sr);
                    req.steps = FULL_STEPS;
                    n_state   = ST_NB;
                end
            end
            ST_NA: begin
                if (rsp.done) begin
                    n_na = rsp.prod[63:0];
                    if (r_sr == '0) begin
                        // x ln x is zero at zero, so the quotient starts now.
                        req.start  = 1'b1;
                        req.is_div = 1'b1;
                        req.a      = rsp.prod[63:0];
                        req.dvs    = 20'(r_sl - r_sr);
                        req.steps  = FULL_STEPS;
                        n_state    = ST_QDIV;
                    end else begin
                        n_x     = r_sr;
                        n_step  = STEP_B;
                        n_state = ST_LN_START;
                    end
                end
            end
            ST_NB: begin
                if (rsp.done) begin
                    req.start  = 1'b1;
                    req.is_div = 1'b1;
                    req.a      = r_na - rsp.prod[63:0];
                    req.dvs    = 20'(r_sl - r_sr);
                    req.steps  = FULL_STEPS;
                    n_state    = ST_QDIV;
                end
            end
            ST_QDIV: begin
                if (rsp.done) begin
                    n_acc   = BIAS_Q44 + rsp.quot - {r_l2[59:0], 4'd0};
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_score = rnd[49:28] - Q16_BIAS;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_score_mode <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_score_mode <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_step  <= n_step;
        r_sl    <= n_sl;
        r_sr    <= n_sr;
        r_x     <= n_x;
        r_e     <= n_e;
        r_atn   <= n_atn;
        r_atd   <= n_atd;
        r_term  <= n_term;
        r_zz    <= n_zz;
        r_sum   <= n_sum;
        r_l2    <= n_l2;
        r_at    <= n_at;
        r_ln    <= n_ln;
        r_na    <= n_na;
        r_acc   <= n_acc;
        r_k     <= n_k;
        r_score <= n_score;
    end

    assign o_out_valid = (r_state == ST_OUT);
    assign o_score     = $signed(r_score);

endmodule
`default_nettype wire

### dv/tb_peto_interval_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peto_interval_score
// Streams grid points through the Peto score block and compares every score
// with a bit-exact fixed-point predictor of the log-rank and Wilcoxon scores.
// ----------------------------------------------------------------------------
module tb_peto_interval_score;
    import pis_pkg::*;

    class peto_scoreboard;
        bit                 log_rank;
        logic [SURV_W-1:0]  held_sl, held_sr, any_sr, after_sr;
        bit                 got_left, got_any, got_after;
        logic [SCORE_W-1:0] score_q[$];
        logic [63:0]        ln2;

        function new();
            log_rank  = 1;
            held_sl   = '0;
            held_sr   = '0;
            any_sr    = '0;
            after_sr  = '0;
            got_left  = 0;
            got_any   = 0;
            got_after = 0;
            ln2       = two_atanh(1, 3);
        endfunction

        function logic [63:0] mul_shr(logic [63:0] x, logic [63:0] y, int s);
            logic [127:0] p;
            p = {64'd0, x} * {64'd0, y};
            return p[s +: 64];
        endfunction

        // 2*atanh(n/d) in Q44, from a Q60 series
        function logic [63:0] two_atanh(logic [63:0] n, logic [63:0] d);
            logic [63:0] rem, z, zz, term, sum, k;
            rem = n;
            z   = 0;
            for (int i = 0; i < 60; i++) begin
                rem = rem << 1;
                z   = z << 1;
                if (rem >= d) begin
                    rem  = rem - d;
                    z[0] = 1'b1;
                end
            end
            zz   = mul_shr(z, z, 60);
            term = z;
            sum  = z;
            for (k = 3; k < 200 && term != 0; k += 2) begin
                term = mul_shr(term, zz, 60);
                sum  = sum + term / k;
            end
            return (sum * 2) >> 16;
        endfunction

        function logic [63:0] ln_q44(logic [63:0] x);
            logic [63:0] e, p;
            e = 0;
            while (e < 16 && (64'd1 << (e + 1)) <= x) e++;
            p = 64'd1 << e;
            return e * ln2 + two_atanh(x - p, x + p);
        endfunction

        function logic [63:0] xlnx(logic [63:0] x);
            if (x == 0) return 0;
            return x * ln_q44(x);
        endfunction

        function logic [SCORE_W-1:0] score_of(logic [SURV_W-1:0] sl, logic [SURV_W-1:0] sr);
            logic [63:0] acc, a, b, r;
            a = {47'd0, sl};
            b = {47'd0, sr};
            if (!log_rank) return SCORE_W'(a + b - 64'(SURV_ONE));
            if (a <= b) begin
                if (a == 0) return SCORE_MIN;
                acc = BIAS_Q44 + ONE_Q44 + ln_q44(a) - 16 * ln2;
            end else begin
                acc = BIAS_Q44 + (xlnx(a) - xlnx(b)) / (a - b) - 16 * ln2;
            end
            r = ((acc + ROUND_HALF) >> 28) - (64'd32 << 16);
            return SCORE_W'(r);
        endfunction

        function void note_word(logic [31:0] lt, logic [31:0] rt, logic [31:0] gt,
                                logic [SURV_W-1:0] sv, logic last);
            logic [SURV_W-1:0] s, sr;
            s = (sv > SURV_ONE) ? SURV_ONE : sv;
            if (!got_left && lt <= gt) begin
                got_left = 1;
                held_sl  = s;
            end
            if (got_left && !got_after && rt <= gt) begin
                got_after = 1;
                after_sr  = s;
            end
            if (!got_any && rt <= gt) begin
                got_any = 1;
                any_sr  = s;
            end
            if (!last) return;
            if (got_left) sr = got_after ? after_sr : held_sr;
            else          sr = got_any ? any_sr : held_sr;
            held_sr   = sr;
            got_left  = 0;
            got_any   = 0;
            got_after = 0;
            score_q.push_back(score_of(held_sl, sr));
        endfunction

        // Returns 0 if the score is unexpected or wrong.
        function bit check_score(logic [SCORE_W-1:0] got, output logic [SCORE_W-1:0] want);
            want = 'x;
            if (score_q.size() == 0) return 0;
            want = score_q.pop_front();
            return got === want;
        endfunction
    endclass

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      i_cfg_wr_en = 0;
    logic                      i_cfg_wr_data = 0;
    logic                      i_in_valid = 0;
    logic                      o_in_ready;
    logic [TIME_W-1:0]         i_left_time = '0;
    logic [TIME_W-1:0]         i_right_time = '0;
    logic [TIME_W-1:0]         i_grid_time = '0;
    logic [SURV_W-1:0]         i_surv_value = '0;
    logic                      i_last_point = 0;
    logic                      o_out_valid;
    logic                      i_out_ready = 0;
    logic signed [SCORE_W-1:0] o_score;

    peto_interval_score dut (.*);

    peto_scoreboard scores = new();
    int  n_errors = 0;
    int  n_words  = 0;
    bit  idle_en  = 1;
    int  out_stall = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("peto_interval_score: mismatch");
        $finish;
    end

    task automatic report(string what);
        n_errors++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    // Accepted words feed the predictor; the output stall is redrawn per score.
    always @(posedge i_clk) begin
        logic [SCORE_W-1:0] want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            scores.note_word(i_left_time, i_right_time, i_grid_time, i_surv_value,
                             i_last_point);
            n_words++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (!scores.check_score(o_score, want))
                report($sformatf("score %h, expected %h", o_score, want));
            out_stall = idle_en ? $urandom_range(0, 14) : 0;
        end
    end

    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            i_out_ready = 0;
            out_stall--;
        end else begin
            i_out_ready = 1;
        end
    end

    task automatic send_word(logic [31:0] lt, logic [31:0] rt, logic [31:0] gt,
                             logic [SURV_W-1:0] sv, logic last);
        int gap;
        gap = idle_en ? $urandom_range(0, 14) : 0;
        repeat (gap) @(negedge i_clk);
        i_left_time  = lt;
        i_right_time = rt;
        i_grid_time  = gt;
        i_surv_value = sv;
        i_last_point = last;
        i_in_valid   = 1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    function automatic logic [SURV_W-1:0] pick_surv();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SURV_ONE;
            2: return SURV_W'($urandom_range(65537, 131071));
            default: return SURV_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // One sample with nondecreasing grid times and the interval ends placed
    // mostly inside the grid span so that both ends are usually found.
    task automatic send_sample(int npts);
        logic [31:0] g0, span, lt, rt, gt;
        g0   = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000);
        span = npts * 20;
        lt   = g0 + $urandom_range(0, span);
        rt   = $urandom_range(0, 4) == 0 ? g0 + $urandom_range(0, span)
                                         : lt + $urandom_range(0, span);
        if ($urandom_range(0, 15) == 0) lt = $urandom;
        if ($urandom_range(0, 15) == 0) rt = $urandom;
        gt = g0;
        for (int i = 0; i < npts; i++) begin
            send_word(lt, rt, gt, pick_surv(), i == npts - 1);
            gt = (gt > 32'hFFFF_FF00) ? gt : gt + $urandom_range(0, 40);
        end
    endtask

    task automatic drain();
        while (scores.score_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_mode(bit m);
        drain();
        i_cfg_wr_en   = 1;
        i_cfg_wr_data = m;
        @(negedge i_clk);
        i_cfg_wr_en = 0;
        scores.log_rank = m;
    endtask

    task automatic directed_part();
        send_word(0, 0, 0, SURV_ONE, 1);
        send_word(0, 0, 0, 0, 1);
        send_word(10, 20, 5, 30000, 0);
        send_word(10, 20, 10, 50000, 0);
        send_word(10, 20, 20, 20000, 1);
        send_word(10, 20, 10, 131071, 0);
        send_word(10, 20, 30, 0, 1);
        send_word('1, '1, 5, 1234, 1);
        send_word('1, '1, '1, 1, 1);
        send_word(100, 10, 50, 40000, 0);
        send_word(100, 10, 200, 9000, 1);
        send_word('1, 0, 7, 65535, 1);
        send_word(3, 3, 3, 32768, 1);
    endtask

    initial begin
        int n_pts;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        directed_part();
        set_mode(0);
        directed_part();
        for (int phase = 0; phase < 4; phase++) begin
            set_mode(phase[0]);
            idle_en = (phase != 2);
            while (n_words < 26 + 160 * (phase + 1)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_word($urandom, $urandom, $urandom, SURV_W'($urandom),
                              $urandom_range(0, 3) == 0);
                end else begin
                    n_pts = $urandom_range(1, 8);
                    send_sample(n_pts);
                end
            end
        end
        drain();
        if (n_errors == 0)
            $display("peto_interval_score: match");
        else
            $display("peto_interval_score: mismatch");
        $finish;
    end

endmodule

### filelist.f
sv/pis_pkg.sv
sv/pis_front.sv
sv/pis_queue.sv
sv/pis_mdu.sv
sv/pis_back.sv
sv/peto_interval_score.sv
dv/tb_peto_interval_score.sv
